>>> rtl/qoi_pixel_encoder_defines.svh
// Assertion macros shared by the checker of the QOI pixel encoder.
`ifndef QOI_PIXEL_ENCODER_DEFINES_SVH
`define QOI_PIXEL_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define QOE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qoi_pixel_encoder: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define QOE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qoi_pixel_encoder: next-cycle check failed");

`endif

>>> rtl/qoienc_pkg.sv
`timescale 1ns / 1ps

package qoienc_pkg;

  localparam int unsigned IndexDepth = 64;
  localparam int unsigned IndexAw    = $clog2(IndexDepth);
  localparam int unsigned MaxBytes   = 6;
  localparam int unsigned LenW       = $clog2(MaxBytes + 1);

  localparam logic [5:0]  RunMax     = 6'd62;
  localparam logic [31:0] ResetPixel = 32'h0000_00FF;

  localparam logic [7:0] OpIndex = 8'h00;
  localparam logic [7:0] OpDiff  = 8'h40;
  localparam logic [7:0] OpLuma  = 8'h80;
  localparam logic [7:0] OpRun   = 8'hC0;
  localparam logic [7:0] OpRgb   = 8'hFE;
  localparam logic [7:0] OpRgba  = 8'hFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       final_pixel;
  } pixel_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_of_burst;
  } code_t;

  // Bytes that one pixel produces; bytes[0] leaves first.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [LenW-1:0]          len;
    logic [5:0]               run_next;
    logic                     wr_en;
  } burst_t;

endpackage

>>> rtl/qoi_pixel_encoder.sv
`timescale 1ns / 1ps

// QOI pixel encoder: RGBA pixels in raster order in, QOI chunk bytes out.
// The input channel carries one pixel per beat, with final_pixel set on the
// last pixel of an image. The output channel carries one chunk byte per beat;
// last_of_burst marks the final byte that a pixel causes. A pixel that only
// extends a run produces no beat. The file header and end marker are not made.
// A pixel is registered at acceptance together with its color index read, and
// is then encoded into a six-byte output buffer once that buffer is empty or
// handing out its last byte, and the buffer offers its first byte from there.
// Throughput is one pixel per cycle while each pixel makes at most one byte and
// the receiver takes every byte. A pixel that makes n bytes hands them out one
// by one on the single-byte output port, and the input is held off until its
// last byte is being taken. When the receiver stalls, the buffer holds its bytes
// and the input stops after one more pixel has been registered.
// Reset and every final pixel clear the 64 index valid bits at once, set the
// previous pixel to opaque black and the run to zero; no clearing pass runs.
module qoi_pixel_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qoienc_pkg::pixel_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qoienc_pkg::code_t   out_data_o
);
  import qoienc_pkg::*;

  logic [31:0]          index_mem [IndexDepth];
  logic [IndexDepth-1:0] valid_q, valid_d;

  logic                 s1_valid_q, s1_valid_d;
  logic [31:0]          s1_px_q;
  logic                 s1_last_q;
  logic [IndexAw-1:0]   s1_pos_q;
  logic [31:0]          rd_data_q;
  logic                 rd_valid_q;
  logic                 fwd_q;
  logic [31:0]          fwd_px_q;
  logic                 clr_q;

  logic [31:0]          prev_q, prev_d;
  logic [5:0]           run_q, run_d;
  logic [MaxBytes-1:0][7:0] buf_q, buf_d;
  logic [LenW-1:0]      len_q, len_d;

  logic                 in_fire, out_fire, commit;
  logic [IndexAw-1:0]   rd_addr;
  logic [31:0]          entry;
  burst_t               burst;

  assign rd_addr = IndexAw'(in_data_i.red[5:0] * 6'd3 + in_data_i.green[5:0] * 6'd5
                          + in_data_i.blue[5:0] * 6'd7 + in_data_i.alpha[5:0] * 6'd11);

  assign out_valid_o = (len_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign commit      = s1_valid_q && ((len_q == '0) || ((len_q == LenW'(1)) && out_ready_i));
  assign in_ready_o  = !s1_valid_q || commit;
  assign in_fire     = in_valid_i && in_ready_o;

  assign out_data_o.code_byte     = buf_q[0];
  assign out_data_o.last_of_burst = (len_q == LenW'(1));

  // The read was taken at entry; a write or clear by the pixel ahead of it in
  // that same cycle is folded in here.
  always_comb begin
    if (clr_q) begin
      entry = '0;
    end else if (fwd_q) begin
      entry = fwd_px_q;
    end else if (rd_valid_q) begin
      entry = rd_data_q;
    end else begin
      entry = '0;
    end
  end

  qoienc_chunk u_chunk (
    .px_i    (s1_px_q),
    .last_i  (s1_last_q),
    .prev_i  (prev_q),
    .run_i   (run_q),
    .entry_i (entry),
    .pos_i   (s1_pos_q),
    .burst_o (burst)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    prev_d     = prev_q;
    run_d      = run_q;
    valid_d    = valid_q;
    buf_d      = buf_q;
    len_d      = len_q;
    if (out_fire) begin
      buf_d = buf_q >> 8;
      len_d = len_q - LenW'(1);
    end
    if (commit) begin
      buf_d = burst.bytes;
      len_d = burst.len;
      if (s1_last_q) begin
        prev_d  = ResetPixel;
        run_d   = 6'd0;
        valid_d = '0;
      end else begin
        prev_d = s1_px_q;
        run_d  = burst.run_next;
        if (burst.wr_en) begin
          valid_d[s1_pos_q] = 1'b1;
        end
      end
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (commit) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      prev_q     <= ResetPixel;
      run_q      <= 6'd0;
      valid_q    <= '0;
      len_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      prev_q     <= prev_d;
      run_q      <= run_d;
      valid_q    <= valid_d;
      len_q      <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (commit && burst.wr_en) begin
      index_mem[s1_pos_q] <= s1_px_q;
    end
    if (in_fire) begin
      s1_px_q    <= {in_data_i.red, in_data_i.green, in_data_i.blue, in_data_i.alpha};
      s1_last_q  <= in_data_i.final_pixel;
      s1_pos_q   <= rd_addr;
      rd_data_q  <= index_mem[rd_addr];
      rd_valid_q <= valid_q[rd_addr];
      fwd_q      <= commit && burst.wr_en && (s1_pos_q == rd_addr);
      fwd_px_q   <= s1_px_q;
      clr_q      <= commit && s1_last_q;
    end
  end

endmodule

>>> rtl/qoienc_chunk.sv
`timescale 1ns / 1ps

module qoienc_chunk (
  input  logic [31:0]                     px_i,
  input  logic                            last_i,
  input  logic [31:0]                     prev_i,
  input  logic [5:0]                      run_i,
  input  logic [31:0]                     entry_i,
  input  logic [qoienc_pkg::IndexAw-1:0]  pos_i,
  output qoienc_pkg::burst_t              burst_o
);
  import qoienc_pkg::*;

  logic [7:0]        r, g, b, a, pr, pg, pb, pa;
  logic signed [7:0] vr, vg, vb;
  logic signed [8:0] vgr, vgb;
  logic [5:0]        run_inc;
  logic [4:0][7:0]   ch;
  logic [LenW-1:0]   ch_len;
  logic              diff_ok, luma_ok;

  assign {r, g, b, a}     = px_i;
  assign {pr, pg, pb, pa} = prev_i;
  assign vr      = signed'(r - pr);
  assign vg      = signed'(g - pg);
  assign vb      = signed'(b - pb);
  assign vgr     = {vr[7], vr} - {vg[7], vg};
  assign vgb     = {vb[7], vb} - {vg[7], vg};
  assign run_inc = run_i + 6'd1;

  assign diff_ok = (vr >= -2) && (vr <= 1) && (vg >= -2) && (vg <= 1)
                && (vb >= -2) && (vb <= 1);
  assign luma_ok = (vgr >= -8) && (vgr <= 7) && (vg >= -32) && (vg <= 31)
                && (vgb >= -8) && (vgb <= 7);

  // Chunk for a pixel that differs from the previous one.
  always_comb begin
    ch     = '0;
    ch_len = '0;
    if (entry_i == px_i) begin
      ch[0]  = OpIndex | {2'b00, pos_i};
      ch_len = LenW'(1);
    end else if (a != pa) begin
      ch     = {a, b, g, r, OpRgba};
      ch_len = LenW'(5);
    end else if (diff_ok) begin
      ch[0]  = OpDiff | {2'b00, 2'(vr + 8'sd2), 2'(vg + 8'sd2), 2'(vb + 8'sd2)};
      ch_len = LenW'(1);
    end else if (luma_ok) begin
      ch[0]  = OpLuma | {2'b00, 6'(vg + 8'sd32)};
      ch[1]  = {4'(vgr + 9'sd8), 4'(vgb + 9'sd8)};
      ch_len = LenW'(2);
    end else begin
      ch     = {8'h00, b, g, r, OpRgb};
      ch_len = LenW'(4);
    end
  end

  always_comb begin
    burst_o = '0;
    if (px_i == prev_i) begin
      if ((run_inc == RunMax) || last_i) begin
        burst_o.bytes[0] = OpRun | {2'b00, run_i};
        burst_o.len      = LenW'(1);
        burst_o.run_next = 6'd0;
      end else begin
        burst_o.run_next = run_inc;
      end
    end else begin
      burst_o.wr_en    = (entry_i != px_i);
      burst_o.run_next = 6'd0;
      if (run_i != 6'd0) begin
        burst_o.bytes[0]   = OpRun | {2'b00, run_i - 6'd1};
        burst_o.bytes[5:1] = ch;
        burst_o.len        = ch_len + LenW'(1);
      end else begin
        burst_o.bytes[4:0] = ch;
        burst_o.len        = ch_len;
      end
    end
  end

endmodule

>>> rtl/qoienc_checker.sv
`timescale 1ns / 1ps
`include "qoi_pixel_encoder_defines.svh"

module qoienc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input qoienc_pkg::pixel_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input qoienc_pkg::code_t   out_data_o
);
  import qoienc_pkg::*;

  logic unused_in;
  assign unused_in = in_valid_i ^ (^in_data_i);

  // A stalled output beat keeps its valid and its payload.
  `QOE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `QOE_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o))
  // The rest of a burst is already buffered when a non-final byte leaves.
  `QOE_ASSERT_NEXT(a_burst_cont, out_valid_o && out_ready_i && !out_data_o.last_of_burst,
                   out_valid_o)
  // The input is only held off while output bytes are pending.
  `QOE_ASSERT_IMPL(a_stall_cause, !in_ready_o, out_valid_o)

endmodule

bind qoi_pixel_encoder qoienc_checker u_checker (.*);

>>> tb/sv/qoi_chunk_checker.sv
`timescale 1ns / 1ps

module qoi_chunk_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  qoienc_pkg::pixel_t in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  qoienc_pkg::code_t  out_data_i,
  output int                 mismatch_count_o,
  output int                 bytes_pending_o
);
  import qoienc_pkg::*;

  logic [31:0] color_table [IndexDepth];
  logic [31:0] prev_rgba;
  logic [5:0]  run_len;
  code_t       chunk_q [$];
  int          mismatches;
  int          byte_no;

  function automatic void clear_encoder_state();
    foreach (color_table[i]) color_table[i] = '0;
    prev_rgba = ResetPixel;
    run_len   = '0;
  endfunction

  // Works out the chunk bytes that one pixel causes and queues them in order.
  function automatic void encode_pixel(input pixel_t px);
    logic [31:0] rgba;
    logic [7:0]  wr, wg, wb;
    logic [7:0]  burst [$];
    logic [5:0]  slot;
    int          hash, dr, dg, db, dgr, dgb;
    rgba = {px.red, px.green, px.blue, px.alpha};
    if (rgba == prev_rgba) begin
      run_len++;
      if (run_len == RunMax || px.final_pixel) begin
        burst.push_back(OpRun | (run_len - 6'd1));
        run_len = '0;
      end
    end else begin
      if (run_len != 0) begin
        burst.push_back(OpRun | (run_len - 6'd1));
        run_len = '0;
      end
      hash = (3 * px.red + 5 * px.green + 7 * px.blue + 11 * px.alpha) % IndexDepth;
      slot = hash[5:0];
      if (color_table[slot] == rgba) begin
        burst.push_back(OpIndex | slot);
      end else begin
        color_table[slot] = rgba;
        if (px.alpha == prev_rgba[7:0]) begin
          // Channel differences wrap at 8 bits and are read as signed values.
          wr  = px.red - prev_rgba[31:24];
          wg  = px.green - prev_rgba[23:16];
          wb  = px.blue - prev_rgba[15:8];
          dr  = $signed(wr);
          dg  = $signed(wg);
          db  = $signed(wb);
          dgr = dr - dg;
          dgb = db - dg;
          if (dr > -3 && dr < 2 && dg > -3 && dg < 2 && db > -3 && db < 2) begin
            burst.push_back(OpDiff | 8'(((dr + 2) << 4) | ((dg + 2) << 2) | (db + 2)));
          end else if (dgr > -9 && dgr < 8 && dg > -33 && dg < 32 &&
                       dgb > -9 && dgb < 8) begin
            burst.push_back(OpLuma | 8'(dg + 32));
            burst.push_back(8'(((dgr + 8) << 4) | (dgb + 8)));
          end else begin
            burst.push_back(OpRgb);
            burst.push_back(px.red);
            burst.push_back(px.green);
            burst.push_back(px.blue);
          end
        end else begin
          burst.push_back(OpRgba);
          burst.push_back(px.red);
          burst.push_back(px.green);
          burst.push_back(px.blue);
          burst.push_back(px.alpha);
        end
      end
    end
    prev_rgba = rgba;
    foreach (burst[i]) chunk_q.push_back({burst[i], i == burst.size() - 1});
    if (px.final_pixel) clear_encoder_state();
  endfunction

  function automatic void check_byte(input code_t got);
    code_t want;
    byte_no++;
    if (chunk_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("qoi_pixel_encoder: beat %0d byte %02h last %0b arrived with none expected",
                 byte_no, got.code_byte, got.last_of_burst);
    end else begin
      want = chunk_q.pop_front();
      if (got.code_byte !== want.code_byte || got.last_of_burst !== want.last_of_burst) begin
        mismatches++;
        if (mismatches <= 10)
          $display("qoi_pixel_encoder: beat %0d expected byte %02h last %0b, got %02h last %0b",
                   byte_no, want.code_byte, want.last_of_burst,
                   got.code_byte, got.last_of_burst);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_encoder_state();
      chunk_q.delete();
      mismatches = 0;
      byte_no    = 0;
      mismatch_count_o <= 0;
      bytes_pending_o  <= 0;
    end else begin
      // A byte leaving now always belongs to a pixel accepted at an earlier edge.
      if (out_valid_i && out_ready_i) check_byte(out_data_i);
      if (in_valid_i && in_ready_i) encode_pixel(in_data_i);
      mismatch_count_o <= mismatches;
      bytes_pending_o  <= chunk_q.size();
    end
  end

endmodule

>>> tb/sv/qoi_pixel_encoder_tb.sv
`timescale 1ns / 1ps

module qoi_pixel_encoder_tb;
  import qoienc_pkg::*;

  typedef enum logic [1:0] {RxSteady, RxCoin, RxSparse, RxMostly} rx_mode_e;

  localparam int unsigned IdleLimit  = 1000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned RandomPixels = 350;

  // Each entry is {r, g, b, a, final_pixel}.
  localparam logic [32:0] DirectedPixels [22] = '{
    {32'h000000FF, 1'b0},  // equal to the reset pixel: starts a run
    {32'h000000FF, 1'b0},
    {32'h00000000, 1'b0},  // flushes the run, then hits the zeroed index
    {32'hFFFFFFFF, 1'b0},  // alpha change
    {32'hFEFEFEFF, 1'b0},  // small step down
    {32'h00FF00FF, 1'b0},  // red wraps past zero
    {32'hFE00FEFF, 1'b0},  // small-difference extremes, green wraps
    {32'hD6E0E5FF, 1'b0},  // green at -32, red-green -8, blue-green +7
    {32'hFCFFFCFF, 1'b0},  // green at +31, red-green +7, blue-green -8
    {32'h1C1F1CFF, 1'b0},  // green +32: just past the luma range
    {32'h1C1F1C80, 1'b0},  // alpha only
    {32'hFFFFFFFF, 1'b0},  // seen before
    {32'hFE00FEFF, 1'b0},
    {32'h12345678, 1'b0},
    {32'h12345678, 1'b0},
    {32'h12345678, 1'b1},  // run closed by the last pixel
    {32'h000000FF, 1'b1},  // one-pixel image equal to the reset pixel
    {32'h00000000, 1'b0},
    {32'h01000000, 1'b0},
    {32'h807F8000, 1'b0},
    {32'h7F808000, 1'b0},
    {32'h7F8080FF, 1'b1}
  };

  logic   clk        = 1'b0;
  logic   rst_n      = 1'b0;
  logic   pix_valid  = 1'b0;
  logic   pix_ready;
  pixel_t pix_data   = '0;
  logic   code_valid;
  logic   code_ready = 1'b0;
  code_t  code_data;
  logic   hold_req   = 1'b0;

  int          mismatch_count;
  int          bytes_pending;
  int unsigned idle_cycles;

  logic [31:0] cur_rgba = ResetPixel;
  logic [31:0] recent_colors [$];
  int          run_left;
  int          burst_left;
  int          img_left;
  bit          no_gaps;

  always #1 clk = ~clk;

  qoi_pixel_encoder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (pix_valid),
    .in_ready_o  (pix_ready),
    .in_data_i   (pix_data),
    .out_valid_o (code_valid),
    .out_ready_i (code_ready),
    .out_data_o  (code_data)
  );

  qoi_chunk_checker chunk_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (pix_valid),
    .in_ready_i       (pix_ready),
    .in_data_i        (pix_data),
    .out_valid_i      (code_valid),
    .out_ready_i      (code_ready),
    .out_data_i       (code_data),
    .mismatch_count_o (mismatch_count),
    .bytes_pending_o  (bytes_pending)
  );

  always_ff @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((pix_valid && pix_ready) || (code_valid && code_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("qoi_pixel_encoder verification failed");
    $finish;
  end

  // Chooses the next pixel so that every chunk kind comes up often.
  function automatic logic [31:0] pick_pixel();
    int          roll, dg;
    logic [7:0]  r, g, b, a;
    {r, g, b, a} = cur_rgba;
    if (run_left > 0) begin
      run_left--;
      return cur_rgba;
    end
    roll = $urandom_range(0, 99);
    if (roll < 18) begin
      // Some runs are long enough to hit the run limit.
      run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 5);
      return cur_rgba;
    end else if (roll < 36) begin
      r = r + 8'($urandom_range(0, 3)) - 8'd2;
      g = g + 8'($urandom_range(0, 3)) - 8'd2;
      b = b + 8'($urandom_range(0, 3)) - 8'd2;
    end else if (roll < 54) begin
      dg = int'($urandom_range(0, 63)) - 32;
      g  = g + 8'(dg);
      r  = r + 8'(dg + int'($urandom_range(0, 15)) - 8);
      b  = b + 8'(dg + int'($urandom_range(0, 15)) - 8);
    end else if (roll < 68) begin
      if (recent_colors.size() != 0)
        return recent_colors[$urandom_range(0, recent_colors.size() - 1)];
    end else if (roll < 82) begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
    end else if (roll < 92) begin
      return $urandom;
    end else begin
      a = 8'($urandom);
    end
    return {r, g, b, a};
  endfunction

  task automatic send_pixel(input logic [31:0] rgba, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
      if (!no_gaps) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 :
              ($urandom_range(0, 7) == 0) ? $urandom_range(7, 15) : $urandom_range(1, 6);
        if (gap != 0) begin
          pix_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    pix_data  <= {rgba, fin};
    pix_valid <= 1'b1;
    do @(posedge clk); while (!pix_ready);
    burst_left--;
    if (fin) begin
      cur_rgba = ResetPixel;
      recent_colors.delete();
    end else begin
      cur_rgba = rgba;
      recent_colors.push_back(rgba);
      if (recent_colors.size() > 16) void'(recent_colors.pop_front());
    end
  endtask

  task automatic wait_for_drain();
    pix_valid <= 1'b0;
    do @(posedge clk); while (bytes_pending != 0);
  endtask

  // Receiver: moves between random stall patterns, and holds off
  // once for a long stretch when asked to.
  initial begin
    rx_mode_e mode;
    int       left;
    bit       hold_done;
    mode      = RxSteady;
    left      = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        code_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 3));
          left = $urandom_range(8, 40);
        end
        left--;
        case (mode)
          RxSteady: code_ready <= 1'b1;
          RxCoin:   code_ready <= 1'($urandom_range(0, 1));
          RxSparse: code_ready <= (left % 4 == 0);
          default:  code_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    int rand_sent;
    run_left   = 0;
    burst_left = 0;
    img_left   = 0;
    no_gaps    = 1'b0;
    rand_sent  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedPixels[i]) send_pixel(DirectedPixels[i][32:1], DirectedPixels[i][0]);
    wait_for_drain();

    // Random images end on a final pixel, so the loop runs the last one out.
    while (rand_sent < RandomPixels || img_left != 0) begin
      if (rand_sent == 120) begin
        hold_req <= 1'b1;
        no_gaps = 1'b1;
      end
      if (rand_sent == 170) no_gaps = 1'b0;
      if (rand_sent == 250) wait_for_drain();
      if (img_left == 0) begin
        img_left = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 140) : $urandom_range(1, 30);
        // The last image is cut short so that the run ends at the pixel target.
        if (img_left > int'(RandomPixels) - rand_sent)
          img_left = int'(RandomPixels) - rand_sent;
      end
      send_pixel(pick_pixel(), img_left == 1);
      img_left--;
      rand_sent++;
    end

    pix_valid <= 1'b0;
    do @(posedge clk); while (bytes_pending != 0);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && bytes_pending == 0) begin
      $display("qoi_pixel_encoder verification clean");
    end else begin
      $display("qoi_pixel_encoder verification failed");
    end
    $finish;
  end

endmodule
